/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent assertions of the port checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* src/rgbhsl_pkg.sv */
// ----------------------------------------------------------------------------
// RGB to HSL package
// Widths and constants shared by the converter and its checkers, and the
// one-bit divider step of the converter.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

	// Field widths.
	localparam int RGB_W  = 8;
	localparam int HUE_W  = 15;
	localparam int SAT_W  = 17;
	localparam int LSUM_W = 9;

	// Divider geometry: a 24-bit dividend, an 8-bit divisor, a 17-bit quotient.
	localparam int DIV_STEPS = SAT_W;
	localparam int REM_W     = RGB_W;
	localparam int DVD_W     = DIV_STEPS + REM_W - 1;
	localparam int NUM_W     = 11;

	// Arithmetic constants.
	localparam logic [LSUM_W-1:0] LSUM_HALF = LSUM_W'(255);
	localparam logic [LSUM_W-1:0] LSUM_MAX  = LSUM_W'(510);
	localparam logic [HUE_W-1:0]  HUE_MAX   = HUE_W'(23039);
	localparam logic [SAT_W-1:0]  SAT_ONE   = SAT_W'(65536);

	// Register stages from the accept edge to the edge that samples done high:
	// input, sort, prepare, the divider steps and the output register.
	localparam int PIPE_DEPTH = DIV_STEPS + 4;

	// One divider lane: partial remainder, dividend bits not yet consumed,
	// quotient so far, divisor and a flag that forces the result to zero.
	typedef struct packed {
		logic [REM_W-1:0]     rem;
		logic [DIV_STEPS-1:0] lo;
		logic [DIV_STEPS-1:0] quo;
		logic [REM_W-1:0]     dvs;
		logic                 zero;
	} div_lane_t;

	// Payload of one divider stage: both lanes and the lightness sum.
	typedef struct packed {
		div_lane_t         hue;
		div_lane_t         sat;
		logic [LSUM_W-1:0] lsum;
	} div_stage_t;

	// One restoring division step: bring down a dividend bit, subtract the
	// divisor when it fits, and shift the new quotient bit in.
	function automatic div_lane_t div_step(input div_lane_t l);
		div_lane_t      n;
		logic [REM_W:0] trial;
		logic [REM_W:0] diff;
		n     = l;
		trial = {l.rem, l.lo[DIV_STEPS-1]};
		diff  = trial - {1'b0, l.dvs};
		if (trial >= {1'b0, l.dvs}) begin
			n.rem = diff[REM_W-1:0];
			n.quo = {l.quo[DIV_STEPS-2:0], 1'b1};
		end else begin
			n.rem = trial[REM_W-1:0];
			n.quo = {l.quo[DIV_STEPS-2:0], 1'b0};
		end
		n.lo = {l.lo[DIV_STEPS-2:0], 1'b0};
		return n;
	endfunction

endpackage

/* src/rgb_to_hsl_pixel_top.sv */
// ----------------------------------------------------------------------------
// RGB to HSL pixel converter
// Turns one 8-bit RGB pixel into hue, saturation and lightness sum through a
// fully pipelined datapath with two restoring dividers.
// ----------------------------------------------------------------------------
// Usage: a pixel is taken at every rising edge where start is high; busy is
// always low, so one pixel per clock is sustained indefinitely. Each pixel
// produces exactly one result word, in input order, with done high for one
// cycle as the word leaves the output register. The receiver must take the
// word in that cycle; there is no back-pressure. The two 17-step bit-serial
// dividers (one quotient bit per stage) sit behind three stages of input
// capture, sorting and operand preparation, and are followed by the output
// register. Hue is in 1/64-degree units, saturation is fixed point with
// 65536 as 1.0, and lightness_sum is max+min.
// ----------------------------------------------------------------------------
module rgb_to_hsl_pixel_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rgbhsl_pkg::RGB_W-1:0]  red,
	input  logic [rgbhsl_pkg::RGB_W-1:0]  green,
	input  logic [rgbhsl_pkg::RGB_W-1:0]  blue,
	output logic                          busy,
	output logic                          done,
	output logic [rgbhsl_pkg::HUE_W-1:0]  hue,
	output logic [rgbhsl_pkg::SAT_W-1:0]  saturation,
	output logic [rgbhsl_pkg::LSUM_W-1:0] lightness_sum
);
	import rgbhsl_pkg::*;

	// Hue sector offsets, in units of chroma.
	localparam logic [2:0] OFF_RED      = 3'd0;
	localparam logic [2:0] OFF_GREEN    = 3'd2;
	localparam logic [2:0] OFF_BLUE     = 3'd4;
	localparam logic [2:0] OFF_RED_WRAP = 3'd6;

	// Stage 1: input capture.
	logic             valid_s1;
	logic [RGB_W-1:0] red_s1;
	logic [RGB_W-1:0] green_s1;
	logic [RGB_W-1:0] blue_s1;

	// Stage 2: sorted channels and sector selection.
	logic              valid_s2;
	logic [RGB_W-1:0]  chroma_s2;
	logic [LSUM_W-1:0] sum_s2;
	logic [2:0]        off_s2;
	logic [RGB_W-1:0]  dpos_s2;
	logic [RGB_W-1:0]  dneg_s2;

	// Stage 3 onward: divider stages, index 0 holds the prepared operands.
	logic [DIV_STEPS:0] valid_div_s;
	div_stage_t         div_s [DIV_STEPS+1];

	// Output register.
	logic              done_q;
	logic [HUE_W-1:0]  hue_q;
	logic [SAT_W-1:0]  sat_q;
	logic [LSUM_W-1:0] lsum_q;

	// Combinational signals of the sort and prepare stages.
	logic [RGB_W-1:0]  max_rg;
	logic [RGB_W-1:0]  min_rg;
	logic [RGB_W-1:0]  max_c;
	logic [RGB_W-1:0]  min_c;
	logic [2:0]        off_c;
	logic [RGB_W-1:0]  dpos_c;
	logic [RGB_W-1:0]  dneg_c;
	logic [NUM_W-1:0]  num_c;
	logic [DVD_W-1:0]  hue_dvd_c;
	logic [DVD_W-1:0]  sat_dvd_c;
	logic [LSUM_W-1:0] den_c;
	div_stage_t        prep_c;

	// The converter never holds off a pixel.
	assign busy = 1'b0;

	// Input capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		red_s1   <= red;
		green_s1 <= green;
		blue_s1  <= blue;
	end

	// Sort the channels and pick the hue sector. Red wins ties over green,
	// green over blue. The hue numerator is off*chroma + dpos - dneg.
	always_comb begin
		max_rg = (red_s1 > green_s1) ? red_s1 : green_s1;
		min_rg = (red_s1 < green_s1) ? red_s1 : green_s1;
		max_c  = (max_rg > blue_s1) ? max_rg : blue_s1;
		min_c  = (min_rg < blue_s1) ? min_rg : blue_s1;
		if (max_c == red_s1) begin
			dpos_c = green_s1;
			dneg_c = blue_s1;
			off_c  = (blue_s1 > green_s1) ? OFF_RED_WRAP : OFF_RED;
		end else if (max_c == green_s1) begin
			dpos_c = blue_s1;
			dneg_c = red_s1;
			off_c  = OFF_GREEN;
		end else begin
			dpos_c = red_s1;
			dneg_c = green_s1;
			off_c  = OFF_BLUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		chroma_s2 <= max_c - min_c;
		sum_s2    <= LSUM_W'(max_c) + LSUM_W'(min_c);
		off_s2    <= off_c;
		dpos_s2   <= dpos_c;
		dneg_s2   <= dneg_c;
	end

	// Prepare both divisions. The hue dividend is 3840 * numerator, built as
	// (num << 12) - (num << 8); the saturation dividend is chroma << 16.
	always_comb begin
		num_c     = NUM_W'(off_s2) * NUM_W'(chroma_s2) + NUM_W'(dpos_s2) - NUM_W'(dneg_s2);
		hue_dvd_c = (DVD_W'(num_c) << 12) - (DVD_W'(num_c) << 8);
		sat_dvd_c = {chroma_s2, {(DVD_W-RGB_W){1'b0}}};
		den_c     = (sum_s2 > LSUM_HALF) ? (LSUM_MAX - sum_s2) : sum_s2;

		prep_c.hue.rem  = {1'b0, hue_dvd_c[DVD_W-1:DIV_STEPS]};
		prep_c.hue.lo   = hue_dvd_c[DIV_STEPS-1:0];
		prep_c.hue.quo  = '0;
		prep_c.hue.dvs  = chroma_s2;
		prep_c.hue.zero = (chroma_s2 == '0);

		prep_c.sat.rem  = {1'b0, sat_dvd_c[DVD_W-1:DIV_STEPS]};
		prep_c.sat.lo   = sat_dvd_c[DIV_STEPS-1:0];
		prep_c.sat.quo  = '0;
		prep_c.sat.dvs  = den_c[REM_W-1:0];
		prep_c.sat.zero = (sum_s2 == '0) || (sum_s2 == LSUM_MAX);

		prep_c.lsum = sum_s2;
	end

	// Valid bits of the divider stages shift along with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_div_s <= '0;
		end else begin
			valid_div_s <= {valid_div_s[DIV_STEPS-1:0], valid_s2};
		end
	end

	always_ff @(posedge clk) begin
		div_s[0] <= prep_c;
	end

	// One quotient bit of each division per stage.
	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
		always_ff @(posedge clk) begin
			div_s[j].hue  <= div_step(div_s[j-1].hue);
			div_s[j].sat  <= div_step(div_s[j-1].sat);
			div_s[j].lsum <= div_s[j-1].lsum;
		end
	end

	// Output register; grey pixels get hue zero, black and white get
	// saturation zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_div_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		hue_q  <= div_s[DIV_STEPS].hue.zero ? '0 : div_s[DIV_STEPS].hue.quo[HUE_W-1:0];
		sat_q  <= div_s[DIV_STEPS].sat.zero ? '0 : div_s[DIV_STEPS].sat.quo;
		lsum_q <= div_s[DIV_STEPS].lsum;
	end

	assign done          = done_q;
	assign hue           = hue_q;
	assign saturation    = sat_q;
	assign lightness_sum = lsum_q;

endmodule

/* src/rgbhsl_checker.sv */
// ----------------------------------------------------------------------------
// RGB to HSL port checker
// Watches the converter's ports for latency, range and special-case rules.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgbhsl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [rgbhsl_pkg::HUE_W-1:0]  hue,
	input logic [rgbhsl_pkg::SAT_W-1:0]  saturation,
	input logic [rgbhsl_pkg::LSUM_W-1:0] lightness_sum
);
	import rgbhsl_pkg::*;

	// Done marks exactly one result word for every accepted pixel, and none otherwise.
	`ASSERT_ALWAYS(a_latency, clk, arst_n, done == $past(start && !busy && arst_n, PIPE_DEPTH), "result word does not match accepted pixel timing")

	// Hue stays inside one turn.
	`ASSERT_IMPLY(a_hue_range, clk, arst_n, done, hue <= HUE_MAX, "hue out of range")

	// Saturation never exceeds 1.0.
	`ASSERT_IMPLY(a_sat_range, clk, arst_n, done, saturation <= SAT_ONE, "saturation out of range")

	// Black and white pixels carry no saturation and no hue.
	`ASSERT_IMPLY(a_black_white, clk, arst_n, done && (lightness_sum == '0 || lightness_sum == LSUM_MAX), saturation == '0 && hue == '0, "black or white pixel with nonzero saturation or hue")

endmodule

bind rgb_to_hsl_pixel_top rgbhsl_checker u_rgbhsl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.hue           (hue),
	.saturation    (saturation),
	.lightness_sum (lightness_sum)
);

/* bench/hsl_checker.sv */
// ----------------------------------------------------------------------------
// RGB to HSL result checker
// Watches the pixel and result channels of the converter. For every pixel it
// takes, the checker computes the hue, saturation and lightness sum it
// expects and queues them. Each result word is then compared field by field
// with the oldest queued expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsl_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [rgbhsl_pkg::RGB_W-1:0]  red,
	input  logic [rgbhsl_pkg::RGB_W-1:0]  green,
	input  logic [rgbhsl_pkg::RGB_W-1:0]  blue,
	input  logic                          done,
	input  logic [rgbhsl_pkg::HUE_W-1:0]  hue,
	input  logic [rgbhsl_pkg::SAT_W-1:0]  saturation,
	input  logic [rgbhsl_pkg::LSUM_W-1:0] lightness_sum,
	output int unsigned                   error_count,
	output int unsigned                   words_pending
);
	import rgbhsl_pkg::*;

	// Hue units in one 60-degree sector: 60 degrees at 1/64 degree each.
	localparam int unsigned HUE_PER_SECTOR = 3840;
	localparam int unsigned MAX_REPORTS    = 10;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [SAT_W-1:0]  sat;
		logic [LSUM_W-1:0] lsum;
	} hsl_t;

	hsl_t        expected_hsl_q[$];
	int unsigned reports;

	// Convert one pixel to its expected hue, saturation and lightness sum.
	function automatic hsl_t hsl_of_pixel(input logic [RGB_W-1:0] r,
		input logic [RGB_W-1:0] g, input logic [RGB_W-1:0] b);
		int unsigned hi;
		int unsigned lo;
		int unsigned chroma;
		int unsigned sum;
		int unsigned den;
		int unsigned num;
		hsl_t        res;
		hi = (r > g) ? r : g;
		hi = (hi > b) ? hi : b;
		lo = (r < g) ? r : g;
		lo = (lo < b) ? lo : b;
		chroma = hi - lo;
		sum = hi + lo;

		// Hue follows the sector of the largest channel; red wins ties, then green.
		if (chroma == 0) begin
			res.hue = '0;
		end else begin
			if (hi == r) begin
				if (b > g)
					num = 6 * chroma - (b - g);
				else
					num = g - b;
			end else if (hi == g) begin
				num = 2 * chroma + b - r;
			end else begin
				num = 4 * chroma + r - g;
			end
			res.hue = HUE_W'((HUE_PER_SECTOR * num) / chroma);
		end

		// Saturation divides by the distance of the sum from the nearer end.
		if (sum == 0 || sum == LSUM_MAX) begin
			res.sat = '0;
		end else begin
			den = (sum > LSUM_HALF) ? LSUM_MAX - sum : sum;
			res.sat = SAT_W'((chroma * SAT_ONE) / den);
		end

		res.lsum = LSUM_W'(sum);
		return res;
	endfunction

	// Compare result words first, then queue the pixel taken at this edge.
	always @(posedge clk or negedge arst_n) begin
		hsl_t exp_w;
		if (!arst_n) begin
			expected_hsl_q.delete();
			error_count   <= 0;
			words_pending <= 0;
			reports = 0;
		end else begin
			if (done) begin
				if (expected_hsl_q.size() == 0) begin
					error_count <= error_count + 1;
					if (reports < MAX_REPORTS) begin
						reports++;
						$display("%0t: unexpected word hue=%0d sat=%0d lsum=%0d",
							$realtime, hue, saturation, lightness_sum);
					end
				end else begin
					exp_w = expected_hsl_q.pop_front();
					if (hue !== exp_w.hue || saturation !== exp_w.sat ||
						lightness_sum !== exp_w.lsum) begin
						error_count <= error_count + 1;
						if (reports < MAX_REPORTS) begin
							reports++;
							$display("%0t: expected h=%0d s=%0d l=%0d got h=%0d s=%0d l=%0d",
								$realtime, exp_w.hue, exp_w.sat, exp_w.lsum,
								hue, saturation, lightness_sum);
						end
					end
				end
			end
			if (start && !busy)
				expected_hsl_q.push_back(hsl_of_pixel(red, green, blue));
			words_pending <= expected_hsl_q.size();
		end
	end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// RGB to HSL converter testbench
// Drives directed corner pixels (black, white, greys, pure and tied
// channels, every hue sector, the saturation turnover around a sum of 255),
// then a long stream of random pixels with random gaps. The checker predicts
// and compares every result word; this module only drives and gives the
// verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import rgbhsl_pkg::*;

	localparam realtime CLK_PERIOD  = 12ns;
	localparam int      RESET_CYC   = 7;
	localparam int      RANDOM_PIX  = 1950;
	localparam int      CALM_FIRST  = 700;
	localparam int      CALM_LAST   = 1200;
	localparam int      DRAIN_AT    = 1500;
	localparam int      LIMIT_CYC   = 200000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic [RGB_W-1:0]  red;
	logic [RGB_W-1:0]  green;
	logic [RGB_W-1:0]  blue;
	logic              busy;
	logic              done;
	logic [HUE_W-1:0]  hue;
	logic [SAT_W-1:0]  saturation;
	logic [LSUM_W-1:0] lightness_sum;
	int unsigned       error_count;
	int unsigned       words_pending;

	rgb_to_hsl_pixel_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.busy         (busy),
		.done         (done),
		.hue          (hue),
		.saturation   (saturation),
		.lightness_sum(lightness_sum)
	);

	hsl_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.done         (done),
		.hue          (hue),
		.saturation   (saturation),
		.lightness_sum(lightness_sum),
		.error_count  (error_count),
		.words_pending(words_pending)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// Offer one pixel and hold it until the converter takes it.
	task automatic send_pixel(input logic [RGB_W-1:0] r, input logic [RGB_W-1:0] g,
		input logic [RGB_W-1:0] b);
		start <= 1'b1;
		red   <= r;
		green <= g;
		blue  <= b;
		do @(posedge clk); while (busy);
	endtask

	// Leave the input idle for a number of cycles.
	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Stop sending until every outstanding word has come back.
	task automatic wait_drained();
		idle_cycles(1);
		while (words_pending != 0) @(posedge clk);
	endtask

	// Random pixel: mostly uniform, with ties, greys, extremes and near-ties mixed in.
	task automatic send_random_pixel();
		logic [RGB_W-1:0] r, g, b;
		int               mode;
		int               pair;
		mode = $urandom_range(0, 99);
		r = $urandom_range(0, 255);
		g = $urandom_range(0, 255);
		b = $urandom_range(0, 255);
		if (mode < 60) begin
			// Uniform channels.
		end else if (mode < 75) begin
			pair = $urandom_range(0, 2);
			case (pair)
				0: g = r;
				1: b = g;
				default: b = r;
			endcase
		end else if (mode < 82) begin
			g = r;
			b = r;
		end else if (mode < 90) begin
			r = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(254, 255)) :
				8'($urandom_range(0, 1));
			g = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(254, 255)) :
				8'($urandom_range(0, 1));
			b = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(254, 255)) :
				8'($urandom_range(0, 1));
		end else begin
			g = r ^ 8'($urandom_range(0, 3));
			b = r ^ 8'($urandom_range(0, 3));
		end
		send_pixel(r, g, b);
	endtask

	// Stimulus and verdict.
	initial begin
		arst_n <= 1'b0;
		start  <= 1'b0;
		red    <= '0;
		green  <= '0;
		blue   <= '0;
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Black, white and grey.
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		// Pure primaries; each also sits at a sum of 255.
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		// Ties for the maximum channel.
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd90, 8'd90, 8'd30);
		// Red maximum with blue above green wraps into the last sector; green and blue maxima follow.
		send_pixel(8'd255, 8'd0, 8'd10);
		send_pixel(8'd200, 8'd100, 8'd101);
		send_pixel(8'd10, 8'd200, 8'd50);
		send_pixel(8'd60, 8'd20, 8'd230);
		// Saturation around the turnover of the sum and at its ends.
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd1, 8'd1);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd127, 8'd127);
		send_pixel(8'd128, 8'd128, 8'd127);
		// Alternating bit patterns.
		send_pixel(8'hAA, 8'h55, 8'hAA);
		send_pixel(8'h55, 8'hAA, 8'h55);
		send_pixel(8'h0F, 8'hF0, 8'h3C);
		wait_drained();

		// Random stream, with one quiet stretch and one full drain partway.
		for (int i = 0; i < RANDOM_PIX; i++) begin
			if (i == DRAIN_AT)
				wait_drained();
			if ((i < CALM_FIRST || i >= CALM_LAST) && $urandom_range(0, 99) < 7)
				idle_cycles(1);
			send_random_pixel();
		end

		wait_drained();
		repeat (PIPE_DEPTH + 4) @(posedge clk);
		if (error_count == 0 && words_pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#(CLK_PERIOD * LIMIT_CYC);
		$display("FAIL");
		$finish;
	end

endmodule
